// File: rtl/bbt_pkg.sv
// ----------------------------------------------------------------------------
// bbt_pkg
// Types, register codes and kernel tables shared by the box blur threshold
// block.
// ----------------------------------------------------------------------------
package bbt_pkg;

  localparam int PIX_W       = 12;
  localparam int ROW_W       = 12;
  localparam int COL_W       = 12;
  localparam int OCOL_W      = 11;
  localparam int WID_W       = 12;
  localparam int HGT_W       = 13;
  localparam int THR_W       = 16;
  localparam int SUM_W       = 16;
  localparam int WSUM_W      = 19;
  localparam int BLUR_W      = 16;
  localparam int LINE_ROWS   = 8;
  localparam int SLOT_W      = 3;
  localparam int MAX_KERNEL  = 9;
  localparam int KSZ_W       = 4;
  localparam int MAX_HEIGHT  = 4096;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  localparam logic [1:0] KSEL_5 = 2'd0;
  localparam logic [1:0] KSEL_7 = 2'd1;
  localparam logic [1:0] KSEL_9 = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  out_row;
    logic [OCOL_W-1:0] out_col;
    logic [BLUR_W-1:0] blurred;
    logic              above_threshold;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
    logic [1:0]       ksel;
    logic [THR_W-1:0] threshold;
  } cfg_t;

  typedef logic [LINE_ROWS-1:0][PIX_W-1:0] taps_t;

  typedef struct packed {
    logic              emit;
    logic              last;
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
  } meta_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    taps_t             taps;
    logic [SLOT_W-1:0] slot;
    meta_t             meta;
  } entry_t;

  function automatic logic [KSZ_W-1:0] kernel_size(input logic [1:0] ksel);
    logic [KSZ_W-1:0] k;
    unique case (ksel)
      KSEL_7:  k = 4'd7;
      KSEL_9:  k = 4'd9;
      default: k = 4'd5;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] kernel_shift(input logic [1:0] ksel);
    logic [1:0] s;
    unique case (ksel)
      KSEL_7:  s = 2'd2;
      KSEL_9:  s = 2'd3;
      default: s = 2'd1;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] kernel_half(input logic [1:0] ksel);
    logic [2:0] h;
    unique case (ksel)
      KSEL_7:  h = 3'd3;
      KSEL_9:  h = 3'd4;
      default: h = 3'd2;
    endcase
    return h;
  endfunction

endpackage

// File: rtl/bbt_front.sv
// ----------------------------------------------------------------------------
// bbt_front
// Accepts pixels, tracks the raster position, classifies each window and
// reads and updates the line store banks.
// ----------------------------------------------------------------------------
module bbt_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bbt_pkg::in_item_t in_data,
  input  bbt_pkg::cfg_t    cfg,
  input  logic             q_full,
  output logic             push,
  output bbt_pkg::entry_t  push_data
);
  import bbt_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              fv_r, fv_nxt;
  entry_t            meta_r, meta_nxt;
  taps_t             taps;
  logic              acc;
  logic [ROW_W-1:0]  r;
  logic [COL_W-1:0]  c;
  logic [AW-1:0]     addr;
  logic [SLOT_W-1:0] slot;
  logic [KSZ_W-1:0]  k;
  logic [2:0]        half;
  logic              row_end, frame_end;

  assign in_stall = fv_r && q_full;
  assign acc      = in_valid && !in_stall;
  assign push     = fv_r && !q_full;

  assign r    = in_data.frame_start ? '0 : row_r;
  assign c    = in_data.frame_start ? '0 : col_r;
  assign addr = AW'(c);
  assign slot = r[SLOT_W-1:0];
  assign k    = kernel_size(cfg.ksel);
  assign half = kernel_half(cfg.ksel);

  assign row_end   = (13'(c) + 13'd1) >= 13'(cfg.width);
  assign frame_end = (13'(r) + 13'd1) >= cfg.height;

  always_comb begin
    meta_nxt           = meta_r;
    meta_nxt.pixel     = in_data.pixel;
    meta_nxt.taps      = '0;
    meta_nxt.slot      = slot;
    meta_nxt.meta.emit = (13'(r) < cfg.height) && (c < cfg.width)
                         && ((13'(r) + 13'd1) >= 13'(k))
                         && ((13'(c) + 13'd1) >= 13'(k));
    meta_nxt.meta.last = ((13'(r) + 13'd1) == cfg.height)
                         && ((13'(c) + 13'd1) == 13'(cfg.width));
    meta_nxt.meta.row  = r - ROW_W'(half);
    meta_nxt.meta.col  = OCOL_W'(c - COL_W'(half));
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    fv_nxt  = fv_r;
    if (push) begin
      fv_nxt = 1'b0;
    end
    if (acc) begin
      fv_nxt = 1'b1;
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : r + 1'b1;
      end else begin
        col_nxt = c + 1'b1;
        row_nxt = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      fv_r  <= 1'b0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      fv_r  <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      meta_r <= meta_nxt;
    end
  end

  for (genvar b = 0; b < LINE_ROWS; b++) begin : g_bank
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_r;

    always_ff @(posedge clk) begin
      if (acc) begin
        rd_r <= mem[addr];
        if (slot == SLOT_W'(b)) begin
          mem[addr] <= in_data.pixel;
        end
      end
    end

    assign taps[b] = rd_r;
  end

  always_comb begin
    push_data      = meta_r;
    push_data.taps = taps;
  end

endmodule

// File: rtl/bbt_fifo.sv
// ----------------------------------------------------------------------------
// bbt_fifo
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module bbt_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bbt_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output bbt_pkg::entry_t q_data
);
  import bbt_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t          store [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;

  assign full    = count_r == CW'(QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign q_data  = store[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/bbt_back.sv
// ----------------------------------------------------------------------------
// bbt_back
// Vertical sum, column sum history, window sum, scaling, threshold compare
// and the output register.
// ----------------------------------------------------------------------------
module bbt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bbt_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  bbt_pkg::entry_t    q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output bbt_pkg::out_item_t out_data
);
  import bbt_pkg::*;

  logic [KSZ_W-1:0]  k;
  logic [1:0]        shift;

  logic              s1v_r;
  meta_t             s1_meta_r;
  logic [SUM_W-1:0]  vsum_r;
  logic [SUM_W-1:0]  vsum_c;
  logic [SLOT_W-1:0] tap_idx;

  logic              s2v_r;
  meta_t             s2_meta_r;
  logic [WSUM_W-1:0] wsum_r;
  logic [WSUM_W-1:0] wsum_c;
  logic [SUM_W-1:0]  term;

  logic [SUM_W-1:0]  colsum_r [MAX_KERNEL];

  logic              ov_r;
  out_item_t         od_r;
  logic [BLUR_W-1:0] blur;

  logic o_free, s2_go, s2_free, s1_go, s1_free;

  assign k     = kernel_size(cfg.ksel);
  assign shift = kernel_shift(cfg.ksel);

  assign o_free  = !ov_r || !out_stall;
  assign s2_go   = s2v_r && (!s2_meta_r.emit || o_free);
  assign s2_free = !s2v_r || s2_go;
  assign s1_go   = s1v_r && s2_free;
  assign s1_free = !s1v_r || s1_go;
  assign pop     = q_valid && s1_free;

  always_comb begin
    tap_idx = '0;
    vsum_c  = SUM_W'(q_data.pixel);
    for (int i = 1; i < MAX_KERNEL; i++) begin
      tap_idx = q_data.slot - SLOT_W'(i);
      if (KSZ_W'(i) < k) begin
        vsum_c = vsum_c + SUM_W'(q_data.taps[tap_idx]);
      end
    end
  end

  always_comb begin
    term   = '0;
    wsum_c = '0;
    for (int i = 0; i < MAX_KERNEL; i++) begin
      term = (i == 0) ? vsum_r : colsum_r[(i == 0) ? 0 : i - 1];
      if (KSZ_W'(i) < k) begin
        wsum_c = wsum_c + WSUM_W'(term);
      end
    end
  end

  assign blur = BLUR_W'(wsum_r >> shift);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1v_r <= 1'b0;
      s2v_r <= 1'b0;
      ov_r  <= 1'b0;
      for (int i = 0; i < MAX_KERNEL; i++) begin
        colsum_r[i] <= '0;
      end
    end else begin
      if (pop) begin
        s1v_r <= 1'b1;
      end else if (s1_go) begin
        s1v_r <= 1'b0;
      end
      if (s1_go) begin
        s2v_r       <= 1'b1;
        colsum_r[0] <= vsum_r;
        for (int i = 1; i < MAX_KERNEL; i++) begin
          colsum_r[i] <= colsum_r[i-1];
        end
      end else if (s2_go) begin
        s2v_r <= 1'b0;
      end
      if (s2_go && s2_meta_r.emit) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_meta_r <= q_data.meta;
      vsum_r    <= vsum_c;
    end
    if (s1_go) begin
      s2_meta_r <= s1_meta_r;
      wsum_r    <= wsum_c;
    end
    if (s2_go && s2_meta_r.emit) begin
      od_r.out_row         <= s2_meta_r.row;
      od_r.out_col         <= s2_meta_r.col;
      od_r.blurred         <= blur;
      od_r.above_threshold <= blur > cfg.threshold;
      od_r.last            <= s2_meta_r.last;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// File: rtl/box_blur_threshold.sv
// ----------------------------------------------------------------------------
// box_blur_threshold
// Streaming k by k box sum (k = 5, 7, 9) with scaling and binary threshold.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// in_       in_valid / in_stall  in_item_t  (pixel, frame_start)
// out_      out_valid / out_stall out_item_t (row, col, blurred, flag, last)
// cfg       psel/penable/pwrite  paddr, pwdata, prdata; pready tied high
//
// One pixel accepted per cycle while in_stall is low; its result passes the
// front register, queue, sum stages and output, held while the output stalls.
// Rate is set by the line store: eight single-port banks, one read of every
// bank and one write per pixel. The four-entry queue absorbs output stalls.
// Synchronous active-low reset clears position and control; the line store
// is not cleared and no sweep runs after reset.
// ----------------------------------------------------------------------------
module box_blur_threshold #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bbt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bbt_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bbt_pkg::*;

  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic [1:0]       ksel_r;
  logic [THR_W-1:0] thresh_r;
  logic [1:0]       reg_idx;
  logic             wr_en;
  cfg_t             cfg;

  logic   q_full, push, pop, q_valid;
  entry_t push_data, q_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd2048;
      height_r <= 13'd2048;
      ksel_r   <= KSEL_5;
      thresh_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH:  width_r  <= pwdata[WID_W-1:0];
        REG_HEIGHT: height_r <= pwdata[HGT_W-1:0];
        REG_KERNEL: ksel_r   <= pwdata[1:0];
        REG_THRESH: thresh_r <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      REG_KERNEL: prdata = 32'(ksel_r);
      REG_THRESH: prdata = 32'(thresh_r);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (width_r == '0) begin
      cfg.width = WID_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      cfg.width = WID_W'(MAX_WIDTH);
    end else begin
      cfg.width = width_r;
    end
    if (height_r == '0) begin
      cfg.height = HGT_W'(1);
    end else if (height_r > HGT_W'(MAX_HEIGHT)) begin
      cfg.height = HGT_W'(MAX_HEIGHT);
    end else begin
      cfg.height = height_r;
    end
    cfg.ksel      = (ksel_r == KSEL_7 || ksel_r == KSEL_9) ? ksel_r : KSEL_5;
    cfg.threshold = thresh_r;
  end

  bbt_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  bbt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  bbt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/bbt_checker.sv
// ----------------------------------------------------------------------------
// bbt_checker
// Port-level checks for the box blur threshold block, bound to the top level.
// ----------------------------------------------------------------------------
module bbt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input bbt_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input bbt_pkg::out_item_t out_data,
  input logic               pready
);
  import bbt_pkg::*;

  localparam logic [BLUR_W-1:0] BLUR_MAX = 16'd51187;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_blur_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.blurred <= BLUR_MAX)
    else $error("blurred value beyond window maximum");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("activity right after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("configuration port not ready");

endmodule

bind box_blur_threshold bbt_checker u_bbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);

// File: test/bbt_checker.sv
// ----------------------------------------------------------------------------
// bbt_scoreboard
// Watches the pixel, result and register ports of the box blur threshold
// block. Keeps its own line store, column sums and frame position, works out
// the blurred result due for each accepted pixel ending a window and compares
// each accepted result, field by field, against the oldest one still due.
// ----------------------------------------------------------------------------
module bbt_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  bbt_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  bbt_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 mismatches,
  output int                 blurs_pending,
  output int                 blurs_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import bbt_pkg::*;

  localparam int STORE_ROWS = 8;
  localparam int STORE_COLS = 2048;
  localparam int WIN_MAX    = 9;
  localparam int SHOW_MAX   = 100;

  logic [11:0] width_q;
  logic [12:0] height_q;
  logic [1:0]  ksel_q;
  logic [15:0] level_q;

  bit [11:0]   line_mem [STORE_ROWS][STORE_COLS];
  int unsigned vsum_hist [WIN_MAX];
  int unsigned row_at;
  int unsigned col_at;
  out_item_t   blur_due [$];
  int          fail_total;
  int          seen_total;
  int          shown;

  task automatic report(input string msg);
    fail_total++;
    if (shown < SHOW_MAX) begin
      $display("[%0t] %s", $realtime, msg);
      shown++;
    end
  endtask

  task automatic blur_window(input in_item_t px);
    int unsigned wid, hgt, k, sh, half, slot, vsum, wsum, r, c, i;
    out_item_t   res;
    wid = (width_q == 0) ? 1 : ((width_q > 2048) ? 2048 : width_q);
    hgt = (height_q == 0) ? 1 : ((height_q > 4096) ? 4096 : height_q);
    case (ksel_q)
      KSEL_7: begin
        k  = 7;
        sh = 2;
      end
      KSEL_9: begin
        k  = 9;
        sh = 3;
      end
      default: begin
        k  = 5;
        sh = 1;
      end
    endcase
    half = (k - 1) / 2;
    if (px.frame_start) begin
      row_at = 0;
      col_at = 0;
    end
    r    = row_at;
    c    = col_at;
    slot = r % STORE_ROWS;
    vsum = px.pixel;
    for (i = 1; i < k; i++)
      vsum += line_mem[(slot + STORE_ROWS - i) % STORE_ROWS][c % STORE_COLS];
    for (i = WIN_MAX - 1; i > 0; i--)
      vsum_hist[i] = vsum_hist[i-1];
    vsum_hist[0] = vsum;
    line_mem[slot][c % STORE_COLS] = px.pixel;
    if (r < hgt && c < wid && r + 1 >= k && c + 1 >= k) begin
      wsum = 0;
      for (i = 0; i < k; i++)
        wsum += vsum_hist[i];
      res.blurred         = 16'(wsum >> sh);
      res.out_row         = 12'(r - half);
      res.out_col         = 11'(c - half);
      res.above_threshold = (res.blurred > level_q);
      res.last            = (r + 1 == hgt && c + 1 == wid);
      blur_due.push_back(res);
    end
    if (c + 1 >= wid) begin
      col_at = 0;
      row_at = (r + 1 >= hgt) ? 0 : r + 1;
    end else begin
      col_at = c + 1;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      width_q  = 12'd2048;
      height_q = 13'd2048;
      ksel_q   = KSEL_5;
      level_q  = '0;
      foreach (vsum_hist[i]) vsum_hist[i] = 0;
      row_at = 0;
      col_at = 0;
      blur_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_WIDTH:  width_q  = pwdata[11:0];
          REG_HEIGHT: height_q = pwdata[12:0];
          REG_KERNEL: ksel_q   = pwdata[1:0];
          REG_THRESH: level_q  = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        blur_window(in_data);
      if (out_valid && !out_stall) begin
        seen_total++;
        if (blur_due.size() == 0) begin
          report($sformatf("result at row %0d col %0d with none due",
                           out_data.out_row, out_data.out_col));
        end else begin
          want = blur_due.pop_front();
          if (out_data.out_row !== want.out_row)
            report($sformatf("out_row %0d, expected %0d", out_data.out_row, want.out_row));
          if (out_data.out_col !== want.out_col)
            report($sformatf("out_col %0d, expected %0d", out_data.out_col, want.out_col));
          if (out_data.blurred !== want.blurred)
            report($sformatf("blurred %0d, expected %0d at row %0d col %0d",
                             out_data.blurred, want.blurred, want.out_row, want.out_col));
          if (out_data.above_threshold !== want.above_threshold)
            report($sformatf("above_threshold %b, expected %b at row %0d col %0d",
                             out_data.above_threshold, want.above_threshold,
                             want.out_row, want.out_col));
          if (out_data.last !== want.last)
            report($sformatf("last %b, expected %b at row %0d col %0d",
                             out_data.last, want.last, want.out_row, want.out_col));
        end
      end
    end
    mismatches    <= fail_total;
    blurs_pending <= blur_due.size();
    blurs_seen    <= seen_total;
  end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel frames and register settings into the box blur threshold
// block: a short frame of full-scale pixels, a priming frame that fills the
// line store, then phases of whole frames, split frames with sizes changed
// mid-frame, stray frame starts and out-of-range register values, with
// random gaps and stalls on both channels. The checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbt_pkg::*;

  localparam int         STUCK_LIMIT = 3000;
  localparam int         DRAIN_WAIT  = 20;
  localparam int         PIXEL_GOAL  = 1450;
  localparam int         PIXEL_CAP   = 1500;
  localparam logic [1:0] KSEL_SPARE  = 2'd3;

  typedef enum int {PH_FRAME, PH_SPLIT, PH_NOISE, PH_WIDE} phase_kind_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int blurs_pending;
  int blurs_seen;
  int items_sent  = 0;
  int stuck_cycles = 0;
  int stall_left   = 0;
  bit tx_calm      = 1'b0;
  bit rx_calm      = 1'b0;

  box_blur_threshold u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  bbt_scoreboard u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches    (mismatches),
    .blurs_pending (blurs_pending),
    .blurs_seen    (blurs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      rx_calm    <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if ($urandom_range(0, 63) == 0) rx_calm <= !rx_calm;
      n = rx_calm ? 0 : $urandom_range(0, 7);
      stall_left <= n;
      out_stall  <= (n != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (stuck_cycles < STUCK_LIMIT);
    $display("timeout: nothing moved for %0d cycles", STUCK_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic set_all(input logic [11:0] wid, input logic [12:0] hgt,
                         input logic [1:0] ks, input logic [15:0] lvl);
    cfg_write(REG_WIDTH, 32'(wid));
    cfg_write(REG_HEIGHT, 32'(hgt));
    cfg_write(REG_KERNEL, 32'(ks));
    cfg_write(REG_THRESH, 32'(lvl));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // flat < 0 draws every pixel at random; fs_odds > 0 scatters frame starts
  task automatic feed(input int count, input bit fs_first, input int flat,
                      input int fs_odds);
    in_item_t item;
    int       gap;
    int       i;
    int       pick;
    for (i = 0; i < count && items_sent < PIXEL_CAP; i++) begin
      gap = tx_calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pick = $urandom_range(0, 15);
      if (flat >= 0) item.pixel = flat[11:0];
      else if (pick == 0) item.pixel = '0;
      else if (pick == 1) item.pixel = '1;
      else item.pixel = 12'($urandom_range(0, 4095));
      item.frame_start = (i == 0 && fs_first) ||
                         (fs_odds > 0 && $urandom_range(0, fs_odds - 1) == 0);
      in_valid <= 1'b1;
      in_data  <= item;
      do @(posedge clk); while (in_stall);
      items_sent++;
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk);
    while (blurs_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_level();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(10000, 35000));
  endfunction

  function automatic int pick_flat();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 0;
    if (r == 1) return 4095;
    return -1;
  endfunction

  initial begin
    phase_kind_t kind;
    int          phase;
    int          wide_no;
    int          wid;
    int          hgt;
    int          r;
    phase   = 0;
    wide_no = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full-scale 5x5 frame: one window at the largest possible blurred value
    set_all(12'd5, 13'd5, KSEL_5, 16'd51186);
    feed(25, 1'b1, 4095, 0);
    settle();

    // fill every line store row over the columns that later windows use
    set_all(12'd32, 13'd9, KSEL_9, pick_level());
    feed(32 * 9, 1'b1, -1, 0);

    while (items_sent < PIXEL_GOAL) begin
      settle();
      tx_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 3);
      if (phase % 3 == 1) kind = PH_WIDE;
      else if (r < 2) kind = PH_FRAME;
      else if (r == 2) kind = PH_SPLIT;
      else kind = PH_NOISE;
      case (kind)
        PH_FRAME: begin
          wid = $urandom_range(5, 32);
          hgt = $urandom_range(1, 12);
          set_all(12'(wid), 13'(hgt), 2'($urandom_range(0, 3)), pick_level());
          feed(wid * hgt * $urandom_range(1, 2), $urandom_range(0, 3) != 0,
               pick_flat(), 0);
        end
        PH_SPLIT: begin
          set_all(12'($urandom_range(0, 32)), 13'($urandom_range(1, 16)),
                  2'($urandom_range(0, 3)), pick_level());
          feed($urandom_range(1, 120), 1'b0, -1, 0);
        end
        PH_NOISE: begin
          set_all(12'($urandom_range(5, 32)), 13'($urandom_range(5, 16)),
                  2'($urandom_range(0, 3)), pick_level());
          feed($urandom_range(30, 200), 1'b1, -1, 12);
        end
        default: begin
          case (wide_no % 4)
            0: set_all(12'hFFF, 13'd0, KSEL_SPARE, 16'h0000);
            1: set_all(12'd2048, 13'd4096, KSEL_9, 16'hFFFF);
            2: set_all(12'd0, 13'h1FFF, KSEL_7, 16'h0000);
            default: set_all(12'd1, 13'd1, KSEL_5, 16'hFFFF);
          endcase
          wide_no++;
          feed($urandom_range(1, 60), 1'b1, -1, 0);
        end
      endcase
      phase++;
    end
    settle();

    $display("%0d pixels sent over %0d register settings, %0d blurred results checked",
             items_sent, phase + 2, blurs_seen);
    $display("%0d mismatches, %0d results still due", mismatches, blurs_pending);
    if (mismatches == 0 && blurs_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bbt_pkg.sv
rtl/bbt_front.sv
rtl/bbt_fifo.sv
rtl/bbt_back.sv
rtl/box_blur_threshold.sv
rtl/bbt_checker.sv
test/bbt_checker.sv
test/tb_top.sv
